@@ rtl/i2cm_pkg.sv @@
package i2cm_pkg;

    localparam int ACTION_W            = 3;
    localparam int BYTE_W              = 8;
    localparam int BIT_COUNT_W         = 4;
    localparam int HALF_PERIOD_W       = 16;
    localparam int CFG_INDEX_W         = 1;
    localparam int CFG_DATA_W          = 16;
    localparam int DELAY_WIDTH_DEFAULT = 16;
    localparam int CHAIN_STEPS         = 6;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET  = 16'd600;
    localparam logic                     SDA_INVERTED_RESET = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SDA_INVERTED = 1'd1;

    localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_ACK  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ_NACK = 3'd5;

    localparam logic [BIT_COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST0  = 5'd1,
        PH_ST1  = 5'd2,
        PH_ST2  = 5'd3,
        PH_ST3  = 5'd4,
        PH_ST4  = 5'd5,
        PH_SP0  = 5'd6,
        PH_SP1  = 5'd7,
        PH_SP2  = 5'd8,
        PH_WR0  = 5'd9,
        PH_WR1  = 5'd10,
        PH_WR2  = 5'd11,
        PH_WR3  = 5'd12,
        PH_WR4  = 5'd13,
        PH_WR5  = 5'd14,
        PH_WR6  = 5'd15,
        PH_RD0  = 5'd16,
        PH_RD1  = 5'd17,
        PH_RD2  = 5'd18,
        PH_RD3  = 5'd19,
        PH_RD4  = 5'd20,
        PH_RD5  = 5'd21,
        PH_RD6  = 5'd22,
        PH_RD7  = 5'd23
    } phase_t;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_FULL,
        WAIT_HALF
    } wait_sel_t;

    typedef struct packed {
        phase_t                 phase;
        logic [BIT_COUNT_W-1:0] bit_count;
        logic [BYTE_W-1:0]      shift_byte;
        logic                   scl;
        logic                   sda;
        logic                   sda_oe;
        logic                   ack_flag;
        logic [BYTE_W-1:0]      rx;
        logic                   read_nack;
    } state_t;

    typedef struct packed {
        state_t    st;
        wait_sel_t wait_sel;
        logic      done;
    } step_t;

    localparam state_t STATE_RESET = '{
        phase:      PH_IDLE,
        bit_count:  '0,
        shift_byte: '0,
        scl:        1'b1,
        sda:        1'b1,
        sda_oe:     1'b1,
        ack_flag:   1'b0,
        rx:         '0,
        read_nack:  1'b0
    };

    // one phase of the bus sequence
    function automatic step_t exec_phase(state_t s, logic sample);
        step_t                  r;
        logic [BIT_COUNT_W-1:0] bc_inc;
        logic [BYTE_W-1:0]      rx_shift;
        r          = '{st: s, wait_sel: WAIT_NONE, done: 1'b0};
        bc_inc     = s.bit_count + 1'b1;
        rx_shift   = {s.shift_byte[BYTE_W-2:0], sample};
        unique case (s.phase)
            PH_ST0:
            begin
                r.st.sda_oe   = 1'b1;
                r.st.sda      = 1'b1;
                r.st.scl      = 1'b1;
                r.st.phase    = PH_ST1;
                r.wait_sel    = WAIT_FULL;
            end
            PH_ST1:
            begin
                r.st.sda      = 1'b0;
                r.st.phase    = PH_ST2;
                r.wait_sel    = WAIT_FULL;
            end
            PH_ST2:
            begin
                r.st.phase    = PH_ST3;
                r.wait_sel    = WAIT_FULL;
            end
            PH_ST3:
            begin
                r.st.scl      = 1'b0;
                r.st.phase    = PH_ST4;
                r.wait_sel    = WAIT_FULL;
            end
            PH_SP0:
            begin
                r.st.sda_oe   = 1'b1;
                r.st.sda      = 1'b0;
                r.st.scl      = 1'b0;
                r.st.phase    = PH_SP1;
                r.wait_sel    = WAIT_FULL;
            end
            PH_SP1:
            begin
                r.st.scl      = 1'b1;
                r.st.phase    = PH_SP2;
                r.wait_sel    = WAIT_FULL;
            end
            PH_SP2:
            begin
                r.st.sda      = 1'b1;
                r.st.phase    = PH_IDLE;
                r.done        = 1'b1;
            end
            PH_WR0:
            begin
                r.st.scl       = 1'b0;
                r.st.bit_count = '0;
                r.st.phase     = PH_WR1;
            end
            PH_WR1:
            begin
                r.st.sda        = s.shift_byte[BYTE_W-1];
                r.st.shift_byte = {s.shift_byte[BYTE_W-2:0], 1'b0};
                r.st.phase      = PH_WR2;
                r.wait_sel      = WAIT_FULL;
            end
            PH_WR2:
            begin
                r.st.scl      = 1'b1;
                r.st.phase    = PH_WR3;
                r.wait_sel    = WAIT_HALF;
            end
            PH_WR3:
            begin
                r.st.scl       = 1'b0;
                r.st.bit_count = bc_inc;
                if (bc_inc < BITS_PER_BYTE)
                begin
                    r.st.phase = PH_WR1;
                end
                else
                begin
                    r.st.sda   = 1'b1;
                    r.st.phase = PH_WR4;
                    r.wait_sel = WAIT_FULL;
                end
            end
            PH_WR4:
            begin
                r.st.sda_oe   = 1'b0;
                r.st.scl      = 1'b1;
                r.st.phase    = PH_WR5;
                r.wait_sel    = WAIT_FULL;
            end
            PH_WR5:
            begin
                r.st.scl      = 1'b0;
                r.st.ack_flag = sample;
                if (sample)
                begin
                    r.st.phase = PH_IDLE;
                    r.done     = 1'b1;
                end
                else
                begin
                    r.st.phase = PH_WR6;
                    r.wait_sel = WAIT_FULL;
                end
            end
            PH_WR6:
            begin
                r.st.sda      = 1'b1;
                r.st.sda_oe   = 1'b1;
                r.st.phase    = PH_IDLE;
                r.done        = 1'b1;
            end
            PH_RD0:
            begin
                r.st.sda_oe     = 1'b0;
                r.st.sda        = 1'b1;
                r.st.shift_byte = '0;
                r.st.bit_count  = '0;
                r.st.phase      = PH_RD1;
            end
            PH_RD1:
            begin
                r.st.scl      = 1'b0;
                r.st.phase    = PH_RD2;
                r.wait_sel    = WAIT_FULL;
            end
            PH_RD2:
            begin
                r.st.scl      = 1'b1;
                r.st.phase    = PH_RD3;
                r.wait_sel    = WAIT_HALF;
            end
            PH_RD3:
            begin
                r.st.shift_byte = rx_shift;
                r.st.bit_count  = bc_inc;
                if (bc_inc < BITS_PER_BYTE)
                begin
                    r.st.phase = PH_RD1;
                end
                else
                begin
                    r.st.rx    = rx_shift;
                    r.st.phase = PH_RD4;
                    r.wait_sel = WAIT_FULL;
                end
            end
            PH_RD4:
            begin
                r.st.scl      = 1'b0;
                r.st.sda_oe   = 1'b1;
                r.st.sda      = s.read_nack;
                r.st.phase    = PH_RD5;
                r.wait_sel    = WAIT_FULL;
            end
            PH_RD5:
            begin
                r.st.scl      = 1'b1;
                r.st.phase    = PH_RD6;
                r.wait_sel    = WAIT_FULL;
            end
            PH_RD6:
            begin
                r.st.scl      = 1'b0;
                if (s.read_nack)
                begin
                    r.st.phase = PH_IDLE;
                    r.done     = 1'b1;
                end
                else
                begin
                    r.st.phase = PH_RD7;
                    r.wait_sel = WAIT_FULL;
                end
            end
            default:
            begin
                r.st.phase    = PH_IDLE;
                r.done        = 1'b1;
            end
        endcase
        return r;
    endfunction

    // whole command in one tick when both waits are zero
    function automatic state_t exec_command(state_t s, logic sample);
        state_t r;
        r = s;
        unique case (s.phase)
            PH_ST0:
            begin
                r.sda_oe = 1'b1;
                r.sda    = 1'b0;
                r.scl    = 1'b0;
            end
            PH_SP0:
            begin
                r.sda_oe = 1'b1;
                r.sda    = 1'b1;
                r.scl    = 1'b1;
            end
            PH_WR0:
            begin
                r.scl        = 1'b0;
                r.sda        = 1'b1;
                r.sda_oe     = !sample;
                r.ack_flag   = sample;
                r.bit_count  = BITS_PER_BYTE;
                r.shift_byte = '0;
            end
            PH_RD0:
            begin
                r.scl        = 1'b0;
                r.sda_oe     = 1'b1;
                r.sda        = s.read_nack;
                r.rx         = {BYTE_W{sample}};
                r.shift_byte = {BYTE_W{sample}};
                r.bit_count  = BITS_PER_BYTE;
            end
            default:
            begin
                r = s;
            end
        endcase
        r.phase = PH_IDLE;
        return r;
    endfunction

endpackage

@@ rtl/i2cm_in_if.sv @@
interface i2cm_in_if;
    logic                          valid;
    logic                          ready;
    logic [i2cm_pkg::ACTION_W-1:0] action;
    logic [i2cm_pkg::BYTE_W-1:0]   tx_byte;
    logic                          sda_sample;

    modport source (output valid, action, tx_byte, sda_sample, input ready);
    modport sink   (input valid, action, tx_byte, sda_sample, output ready);
endinterface

@@ rtl/i2cm_out_if.sv @@
interface i2cm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        scl_level;
    logic                        sda_level;
    logic                        sda_drive_enable;
    logic                        busy_res;
    logic                        done_res;
    logic [i2cm_pkg::BYTE_W-1:0] rx_byte;
    logic                        ack_missing;

    modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
                    done_res, rx_byte, ack_missing, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
                    done_res, rx_byte, ack_missing, output ready);
endinterface

@@ rtl/i2c_master_byte_engine_top.sv @@
// Path: an input transfer is held in the input register, passes once through the
//   bus-sequencer logic and lands in the result register before its result transfer.
// Throughput: one tick per cycle unless out_ch stalls; each tick resolves up to six
//   chained zero-wait phases, or a whole command at once when both waits are zero.
// Reset: asynchronous, active low; idle, SCL and SDA driven high, half_period 600,
//   sda_inverted 1, no transfers pending; the output registers are not reset.
module i2c_master_byte_engine_top #(
    parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,
    i2cm_in_if.sink                          in_ch,
    i2cm_out_if.source                       out_ch
);
    import i2cm_pkg::*;

    localparam int HP_EXT_W = HALF_PERIOD_W + DELAY_WIDTH;

    logic [HALF_PERIOD_W-1:0] half_period_reg;
    logic                     sda_inverted_reg;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [ACTION_W-1:0]      s1_action_reg;
    logic [BYTE_W-1:0]        s1_tx_reg;
    logic                     s1_sample_reg;

    state_t                   state_reg;
    state_t                   state_next;
    logic [DELAY_WIDTH-1:0]   timer_reg;
    logic [DELAY_WIDTH-1:0]   timer_next;
    logic                     done_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     scl_reg;
    logic                     sda_reg;
    logic                     oe_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [BYTE_W-1:0]        rx_reg;
    logic                     ack_reg;

    logic [HP_EXT_W-1:0]      hp_ext;
    logic [DELAY_WIDTH-1:0]   full_wait;
    logic [DELAY_WIDTH-1:0]   half_wait;
    logic                     both_zero;
    logic                     in_xfer;
    logic                     s1_fire;

    assign hp_ext    = {{DELAY_WIDTH{1'b0}}, half_period_reg};
    assign full_wait = hp_ext[DELAY_WIDTH-1:0];
    assign half_wait = hp_ext[DELAY_WIDTH:1];
    assign both_zero = (full_wait == '0) && (half_wait == '0);

    assign s1_fire     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_fire;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // bus sequencer: one tick
    always_comb
    begin
        state_t                 s;
        step_t                  stp;
        logic [DELAY_WIDTH-1:0] t;
        logic                   cmd_start;
        s         = state_reg;
        stp       = '0;
        t         = timer_reg;
        done_next = 1'b0;
        cmd_start = 1'b0;
        if (s.phase == PH_IDLE)
        begin
            cmd_start = 1'b1;
            unique case (s1_action_reg)
                ACT_START:
                begin
                    s.phase = PH_ST0;
                end
                ACT_STOP:
                begin
                    s.phase = PH_SP0;
                end
                ACT_WRITE:
                begin
                    s.shift_byte = s1_tx_reg;
                    s.phase      = PH_WR0;
                end
                ACT_READ_ACK:
                begin
                    s.read_nack = 1'b0;
                    s.phase     = PH_RD0;
                end
                ACT_READ_NACK:
                begin
                    s.read_nack = 1'b1;
                    s.phase     = PH_RD0;
                end
                default:
                begin
                    cmd_start = 1'b0;
                end
            endcase
        end
        else if (t != '0)
        begin
            t = t - 1'b1;
        end

        if (cmd_start && both_zero)
        begin
            s         = exec_command(s, s1_sample_reg);
            t         = '0;
            done_next = 1'b1;
        end
        else
        begin
            for (int k = 0; k < CHAIN_STEPS; k++)
            begin
                if ((s.phase != PH_IDLE) && (t == '0))
                begin
                    stp       = exec_phase(s, s1_sample_reg);
                    s         = stp.st;
                    done_next = done_next | stp.done;
                    unique case (stp.wait_sel)
                        WAIT_FULL: t = full_wait;
                        WAIT_HALF: t = half_wait;
                        default:   t = '0;
                    endcase
                end
            end
        end
        state_next = s;
        timer_next = t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg  <= HALF_PERIOD_RESET;
            sda_inverted_reg <= SDA_INVERTED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD:  half_period_reg  <= cfg_data[HALF_PERIOD_W-1:0];
                CFG_SDA_INVERTED: sda_inverted_reg <= cfg_data[0];
                default:          half_period_reg  <= half_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            timer_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                state_reg <= state_next;
                timer_reg <= timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_action_reg <= in_ch.action;
            s1_tx_reg     <= in_ch.tx_byte;
            s1_sample_reg <= in_ch.sda_sample;
        end
        if (s1_fire)
        begin
            scl_reg  <= state_next.scl;
            sda_reg  <= state_next.sda ^ sda_inverted_reg;
            oe_reg   <= state_next.sda_oe;
            busy_reg <= (state_next.phase != PH_IDLE);
            done_reg <= done_next;
            rx_reg   <= state_next.rx;
            ack_reg  <= state_next.ack_flag;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.scl_level        = scl_reg;
    assign out_ch.sda_level        = sda_reg;
    assign out_ch.sda_drive_enable = oe_reg;
    assign out_ch.busy_res         = busy_reg;
    assign out_ch.done_res         = done_reg;
    assign out_ch.rx_byte          = rx_reg;
    assign out_ch.ack_missing      = ack_reg;

    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_IDLE) |-> (timer_reg == '0))
        else $error("timer running while sequencer idle");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_count <= BITS_PER_BYTE)
        else $error("bit count beyond one byte");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> !busy_reg)
        else $error("command reported done while still busy");

endmodule
